/* rtl/ccs_pkg.sv */
`default_nettype none

package ccs_pkg;

    localparam int CharWidth  = 8;
    localparam int ClassWidth = 2;

    localparam logic [CharWidth-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CharWidth-1:0] CH_STAR    = 8'h2A;
    localparam logic [CharWidth-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CharWidth-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [ClassWidth-1:0] CLASS_CODE    = 2'd0;
    localparam logic [ClassWidth-1:0] CLASS_STRING  = 2'd1;
    localparam logic [ClassWidth-1:0] CLASS_COMMENT = 2'd2;

    // One labelled byte as it leaves the block.
    typedef struct packed {
        logic [CharWidth-1:0]  out_char;
        logic [ClassWidth-1:0] char_class;
        logic                  last;
    } result_t;

    // What the lexer makes of one input beat: up to two results, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } lex_out_t;

endpackage

`default_nettype wire

/* rtl/ccs_in_if.sv */
`default_nettype none

interface ccs_in_if;

    logic                          valid;
    logic                          ready;
    logic [ccs_pkg::CharWidth-1:0] ch;
    logic                          end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);

endinterface

`default_nettype wire

/* rtl/ccs_out_if.sv */
`default_nettype none

interface ccs_out_if;

    logic                           valid;
    logic                           ready;
    logic [ccs_pkg::CharWidth-1:0]  out_char;
    logic [ccs_pkg::ClassWidth-1:0] char_class;
    logic                           last;

    modport source (output valid, output out_char, output char_class, output last,
                    input ready);
    modport sink   (input valid, input out_char, input char_class, input last,
                    output ready);

endinterface

`default_nettype wire

/* rtl/ccs_lexer.sv */
`default_nettype none

module ccs_lexer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [ccs_pkg::CharWidth-1:0] ch,
    input  wire logic                          end_of_text,
    output ccs_pkg::lex_out_t                  lex
);

    localparam logic [2:0] MODE_CODE   = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_STRING = 3'd2;
    localparam logic [2:0] MODE_LINE   = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;
    localparam logic [2:0] MODE_STAR   = 3'd5;

    logic [2:0]       mode_reg;
    logic [2:0]       mode_next;
    ccs_pkg::result_t r0;
    ccs_pkg::result_t r1;
    logic [1:0]       n;

    always_comb
    begin
        mode_next = mode_reg;
        n         = 2'd0;
        r0        = '{out_char: ch, char_class: ccs_pkg::CLASS_CODE, last: 1'b0};
        r1        = '{out_char: ch, char_class: ccs_pkg::CLASS_CODE, last: 1'b0};

        case (mode_reg)
            MODE_SLASH:
            begin
                if (ch == ccs_pkg::CH_SLASH || ch == ccs_pkg::CH_STAR)
                begin
                    r0.out_char   = ccs_pkg::CH_SLASH;
                    r0.char_class = ccs_pkg::CLASS_COMMENT;
                    r1.char_class = ccs_pkg::CLASS_COMMENT;
                    n             = 2'd2;
                    mode_next     = (ch == ccs_pkg::CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                end
                else
                begin
                    // The held slash was plain code; the new byte starts afresh.
                    r0.out_char = ccs_pkg::CH_SLASH;
                    if (ch == ccs_pkg::CH_QUOTE)
                    begin
                        r1.char_class = ccs_pkg::CLASS_STRING;
                        n             = 2'd2;
                        mode_next     = MODE_STRING;
                    end
                    else if (ch == ccs_pkg::CH_SLASH)
                    begin
                        n         = 2'd1;
                        mode_next = MODE_SLASH;
                    end
                    else
                    begin
                        n         = 2'd2;
                        mode_next = MODE_CODE;
                    end
                end
            end
            MODE_STRING:
            begin
                r0.char_class = ccs_pkg::CLASS_STRING;
                n             = 2'd1;
                if (ch == ccs_pkg::CH_QUOTE)
                    mode_next = MODE_CODE;
            end
            MODE_LINE:
            begin
                n = 2'd1;
                if (ch == ccs_pkg::CH_NEWLINE)
                    mode_next = MODE_CODE;
                else
                    r0.char_class = ccs_pkg::CLASS_COMMENT;
            end
            MODE_BLOCK:
            begin
                r0.char_class = ccs_pkg::CLASS_COMMENT;
                n             = 2'd1;
                if (ch == ccs_pkg::CH_STAR)
                    mode_next = MODE_STAR;
            end
            MODE_STAR:
            begin
                r0.char_class = ccs_pkg::CLASS_COMMENT;
                n             = 2'd1;
                if (ch == ccs_pkg::CH_SLASH)
                    mode_next = MODE_CODE;
                else if (ch != ccs_pkg::CH_STAR)
                    mode_next = MODE_BLOCK;
            end
            default:
            begin
                if (ch == ccs_pkg::CH_QUOTE)
                begin
                    r0.char_class = ccs_pkg::CLASS_STRING;
                    n             = 2'd1;
                    mode_next     = MODE_STRING;
                end
                else if (ch == ccs_pkg::CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else
                begin
                    n         = 2'd1;
                    mode_next = MODE_CODE;
                end
            end
        endcase

        // At the end of the text a slash still held goes out as code.
        if (end_of_text)
        begin
            if (mode_next == MODE_SLASH)
            begin
                if (n == 2'd0)
                begin
                    r0.out_char   = ccs_pkg::CH_SLASH;
                    r0.char_class = ccs_pkg::CLASS_CODE;
                    n             = 2'd1;
                end
                else
                begin
                    r1.out_char   = ccs_pkg::CH_SLASH;
                    r1.char_class = ccs_pkg::CLASS_CODE;
                    n             = 2'd2;
                end
            end
            mode_next = MODE_CODE;
        end

        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_CODE;
        else if (advance)
            mode_reg <= mode_next;
    end

    assign lex.count  = n;
    assign lex.first  = r0;
    assign lex.second = r1;

endmodule

`default_nettype wire

/* rtl/ccs_result_buf.sv */
`default_nettype none

module ccs_result_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ccs_pkg::lex_out_t lex,
    input  wire logic              take,
    output logic                   can_load,
    output logic                   has_data,
    output ccs_pkg::result_t       head
);

    ccs_pkg::result_t slot0_reg;
    ccs_pkg::result_t slot1_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign has_data = (count_reg != 2'd0);
    assign pop      = has_data && take;
    // A new beat may land when the buffer will be empty by the end of this cycle.
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && take);
    assign head     = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (load)
            count_next = lex.count;
        else if (pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= lex.first;
            slot1_reg <= lex.second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/code_comment_splitter.sv */
`default_nettype none

// Channel  | Dir | Payload                            | Beat
// ---------+-----+------------------------------------+------------------------------
// text     | in  | ch[7:0], end_of_text               | one source byte
// labels   | out | out_char[7:0], char_class[1:0], last| one labelled byte
//
// A byte is classified in the cycle it is accepted and its zero, one or two results
// land in a two-entry result buffer; the first result is visible the next cycle.
// A byte that yields one result can follow every cycle while labels.ready is high;
// a byte that yields two holds the input while the buffer drains.
// rst_n clears the lexer mode (code, no held slash) and empties the result buffer.
// A stall on labels holds the buffer and, once it is not about to empty, text.ready.
module code_comment_splitter (
    input  wire logic clk,
    input  wire logic rst_n,
    ccs_in_if.sink    text,
    ccs_out_if.source labels
);

    ccs_pkg::lex_out_t lex;
    ccs_pkg::result_t  head;
    logic              can_load;
    logic              has_data;
    logic              advance;

    assign text.ready = can_load;
    assign advance    = text.valid && can_load;

    ccs_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .ch          (text.ch),
        .end_of_text (text.end_of_text),
        .lex         (lex)
    );

    ccs_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .lex      (lex),
        .take     (labels.ready),
        .can_load (can_load),
        .has_data (has_data),
        .head     (head)
    );

    assign labels.valid      = has_data;
    assign labels.out_char   = head.out_char;
    assign labels.char_class = head.char_class;
    assign labels.last       = head.last;

endmodule

`default_nettype wire
